[hdl/rsc_pkg.sv]
// rsc_pkg: shared constants, payload types and helpers of the rpn stack calculator
// depends on nothing; used by every file under hdl
`timescale 1ns / 1ps
`default_nettype none

package rsc_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int FRAC_BITS   = 16;
	localparam int DATA_W      = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int SHOW_W      = $clog2(STACK_DEPTH);
	localparam int QUOT_W      = DATA_W + FRAC_BITS;
	localparam int QCNT_W      = $clog2(QUOT_W + 1);

	// half an lsb of the product, zero when there are no fraction bits
	localparam logic [63:0] MUL_ROUND = (64'd1 << FRAC_BITS) >> 1;

	typedef enum logic [2:0] {
		OP_PUSH    = 3'd0,
		OP_ADD     = 3'd1,
		OP_SUB     = 3'd2,
		OP_MUL     = 3'd3,
		OP_DIV     = 3'd4,
		OP_CLEAR   = 3'd5,
		OP_SHOW    = 3'd6,
		OP_INVALID = 3'd7
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_ACK    = 2'd0,
		KIND_RESULT = 2'd1,
		KIND_ENTRY  = 2'd2,
		KIND_EMPTY  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_OVERFLOW  = 3'd1,
		ST_UNDERFLOW = 3'd2,
		ST_BAD_OP    = 3'd3,
		ST_DIV_ZERO  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_SHOW
	} state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_FROM_ABOVE,
		CELL_FROM_BELOW
	} cell_op_t;

	typedef struct packed {
		opcode_t                   opcode;
		logic signed [DATA_W-1:0]  operand_value;
	} cmd_t;

	typedef struct packed {
		kind_t                     kind;
		logic signed [DATA_W-1:0]  value;
		status_t                   status;
		logic [6:0]                entries_held;
		logic                      is_last;
	} result_t;

	// moves for the head cell and for all the others
	typedef struct packed {
		cell_op_t             head;
		cell_op_t             body;
		logic [DATA_W-1:0]    head_in;
	} chain_ctl_t;

	typedef struct packed {
		logic                 start;
		logic [DATA_W-1:0]    num_mag;
		logic [DATA_W-1:0]    den_mag;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [QUOT_W-1:0]    quot;
		logic                 round_up;
	} div_rsp_t;

	function automatic logic [DATA_W-1:0] mag_of(input logic [DATA_W-1:0] v);
		logic [DATA_W-1:0] m;
		m = v[DATA_W-1] ? (~v + 1'b1) : v;
		return m;
	endfunction

	// apply the sign to a magnitude and saturate to the q16.16 range
	function automatic logic [DATA_W-1:0] sat_mag(input logic [63:0] mag, input logic neg);
		logic [DATA_W-1:0] r;
		if (neg) begin
			if (mag > 64'h0000_0000_8000_0000) r = {1'b1, {(DATA_W-1){1'b0}}};
			else r = ~mag[DATA_W-1:0] + 1'b1;
		end else begin
			if (mag > 64'h0000_0000_7FFF_FFFF) r = {1'b0, {(DATA_W-1){1'b1}}};
			else r = mag[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[hdl/rsc_cell.sv]
// rsc_cell: one stack entry of the operand chain
// depends on rsc_pkg for the cell move codes
`timescale 1ns / 1ps
`default_nettype none

module rsc_cell (
	input  wire logic                         clk,
	input  rsc_pkg::cell_op_t                 op,
	input  wire logic [rsc_pkg::DATA_W-1:0]   above,
	input  wire logic [rsc_pkg::DATA_W-1:0]   below,
	output logic [rsc_pkg::DATA_W-1:0]        val
);

	logic [rsc_pkg::DATA_W-1:0] val_q;

	always_ff @(posedge clk) begin
		unique case (op)
			rsc_pkg::CELL_FROM_ABOVE: val_q <= above;
			rsc_pkg::CELL_FROM_BELOW: val_q <= below;
			default:                  val_q <= val_q;
		endcase
	end

	assign val = val_q;

endmodule

`default_nettype wire

[hdl/rsc_div.sv]
// rsc_div: restoring magnitude divider, one quotient bit per cycle
// depends on rsc_pkg for widths and the request and response structs
`timescale 1ns / 1ps
`default_nettype none

module rsc_div (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  rsc_pkg::div_req_t req,
	output rsc_pkg::div_rsp_t rsp
);

	logic [rsc_pkg::QUOT_W-1:0] dq_q;
	logic [rsc_pkg::DATA_W-1:0] rem_q;
	logic [rsc_pkg::DATA_W-1:0] den_q;
	logic [rsc_pkg::QCNT_W-1:0] cnt_q;
	logic                       run_q;
	logic                       done_q;
	logic [rsc_pkg::DATA_W:0]   trial;
	logic [rsc_pkg::DATA_W:0]   diff;
	logic                       fits;

	assign trial = {rem_q, dq_q[rsc_pkg::QUOT_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= rsc_pkg::QCNT_W'(rsc_pkg::QUOT_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == rsc_pkg::QCNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend bits leave at the top while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= rsc_pkg::QUOT_W'(req.num_mag) << rsc_pkg::FRAC_BITS;
			rem_q <= '0;
			den_q <= req.den_mag;
		end else if (run_q) begin
			dq_q  <= {dq_q[rsc_pkg::QUOT_W-2:0], fits};
			rem_q <= fits ? diff[rsc_pkg::DATA_W-1:0] : trial[rsc_pkg::DATA_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quot     = dq_q;
	assign rsp.round_up = {rem_q, 1'b0} >= {1'b0, den_q};

endmodule

`default_nettype wire

[hdl/rpn_stack_calculator_top.sv]
// rpn_stack_calculator_top: reverse polish calculator over a chain of stack cells
// depends on rsc_pkg, rsc_cell and rsc_div
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Command channel: a beat (cmd) is taken at a rising edge with start high and
//   busy low. Result channel: each result sits on result for one cycle with
//   strobe high; the receiver cannot stall it and must take every beat.
//   The stack is a row of STACK_DEPTH cells, top of stack in cell 0. Push shifts
//   the row down; an arithmetic result lands in cell 0 while the rest shifts up.
//   How each command reaches its strobe:
//     push, add, sub, clear, invalid and show on an empty stack: strobe in
//     the cycle after the accepting edge
//     mul: registered 32x32 product, then round and saturate
//     div: one quotient bit per cycle in rsc_div
//     show: the row rotates once around all STACK_DEPTH cells; entries leave the bottom
//     cell on the last entries_held steps, one beat per cycle, bottom entry first.
//   busy is high while mul, div or show is in flight; the other commands keep
//   it low, so one can be taken every cycle.
//   Reset empties the stack and idles the block; cell contents are not cleared.
module rpn_stack_calculator_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  rsc_pkg::cmd_t   cmd,
	output logic            strobe,
	output rsc_pkg::result_t result
);

	localparam int D = rsc_pkg::STACK_DEPTH;
	localparam int W = rsc_pkg::DATA_W;

	rsc_pkg::state_t            state_q, state_d;
	logic [rsc_pkg::CNT_W-1:0]  count_q, count_d;
	logic [rsc_pkg::SHOW_W-1:0] step_q;
	logic [63:0]                prod_q;
	logic                       neg_q;
	rsc_pkg::result_t           out_q, out_d;
	logic                       strobe_q, strobe_d;

	rsc_pkg::chain_ctl_t        ctl;
	rsc_pkg::div_req_t          dreq;
	rsc_pkg::div_rsp_t          drsp;
	logic [W-1:0]               cell_val [D];

	logic                       accept;
	logic                       few, full, empty, b_zero;
	logic [W-1:0]               b_val, a_val, a_mag, b_mag;
	logic                       neg;
	logic [W:0]                 sum_x, dif_x;
	logic [W-1:0]               sum_sat, dif_sat, mul_res, div_res;
	logic [63:0]                mul_round;
	logic [rsc_pkg::CNT_W:0]    show_pos;
	logic                       show_emit, show_last;

	// chain of cells
	for (genvar i = 0; i < D; i++) begin : g_cell
		logic [W-1:0] above_v, below_v;
		if (i == 0) begin : g_head
			assign above_v = ctl.head_in;
		end else begin : g_body
			assign above_v = cell_val[i-1];
		end
		if (i == D - 1) begin : g_tail
			assign below_v = cell_val[i];
		end else begin : g_inner
			assign below_v = cell_val[i+1];
		end
		rsc_cell u_cell (
			.clk   (clk),
			.op    ((i == 0) ? ctl.head : ctl.body),
			.above (above_v),
			.below (below_v),
			.val   (cell_val[i])
		);
	end

	rsc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign accept = start && (state_q == rsc_pkg::S_IDLE);
	assign busy   = (state_q != rsc_pkg::S_IDLE);

	assign few    = count_q < rsc_pkg::CNT_W'(2);
	assign full   = count_q == rsc_pkg::CNT_W'(D);
	assign empty  = count_q == '0;

	// right operand on top, left one just below
	assign b_val  = cell_val[0];
	assign a_val  = cell_val[1];
	assign a_mag  = rsc_pkg::mag_of(a_val);
	assign b_mag  = rsc_pkg::mag_of(b_val);
	assign neg    = a_val[W-1] ^ b_val[W-1];
	assign b_zero = b_val == '0;

	assign sum_x  = {a_val[W-1], a_val} + {b_val[W-1], b_val};
	assign dif_x  = {a_val[W-1], a_val} - {b_val[W-1], b_val};
	assign sum_sat = (sum_x[W] != sum_x[W-1]) ? {sum_x[W], {(W-1){~sum_x[W]}}} : sum_x[W-1:0];
	assign dif_sat = (dif_x[W] != dif_x[W-1]) ? {dif_x[W], {(W-1){~dif_x[W]}}} : dif_x[W-1:0];

	assign mul_round = (prod_q + rsc_pkg::MUL_ROUND) >> rsc_pkg::FRAC_BITS;
	assign mul_res   = rsc_pkg::sat_mag(mul_round, neg_q);
	assign div_res   = rsc_pkg::sat_mag(64'(drsp.quot) + 64'(drsp.round_up), neg_q);

	// entries leave the tail cell during the last count_q steps of the rotation
	assign show_pos  = (rsc_pkg::CNT_W+1)'(step_q) + (rsc_pkg::CNT_W+1)'(count_q);
	assign show_emit = show_pos >= (rsc_pkg::CNT_W+1)'(D);
	assign show_last = step_q == rsc_pkg::SHOW_W'(D - 1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rsc_pkg::S_IDLE: begin
				if (accept) begin
					unique case (cmd.opcode)
						rsc_pkg::OP_MUL:  if (!few) state_d = rsc_pkg::S_MUL;
						rsc_pkg::OP_DIV:  if (!few && !b_zero) state_d = rsc_pkg::S_DIV;
						rsc_pkg::OP_SHOW: if (!empty) state_d = rsc_pkg::S_SHOW;
						default:          state_d = rsc_pkg::S_IDLE;
					endcase
				end
			end
			rsc_pkg::S_MUL:  state_d = rsc_pkg::S_IDLE;
			rsc_pkg::S_DIV:  if (drsp.done) state_d = rsc_pkg::S_IDLE;
			rsc_pkg::S_SHOW: if (show_last) state_d = rsc_pkg::S_IDLE;
			default:         state_d = rsc_pkg::S_IDLE;
		endcase
	end

	// chain moves, stack count and the result beat
	always_comb begin
		ctl.head            = rsc_pkg::CELL_HOLD;
		ctl.body            = rsc_pkg::CELL_HOLD;
		ctl.head_in         = cmd.operand_value;
		count_d             = count_q;
		strobe_d            = 1'b0;
		out_d.kind          = rsc_pkg::KIND_ACK;
		out_d.value         = '0;
		out_d.status        = rsc_pkg::ST_OK;
		out_d.is_last       = 1'b1;
		dreq.start          = 1'b0;
		dreq.num_mag        = a_mag;
		dreq.den_mag        = b_mag;
		unique case (state_q)
			rsc_pkg::S_IDLE: begin
				if (accept) begin
					strobe_d = 1'b1;
					unique case (cmd.opcode)
						rsc_pkg::OP_PUSH: begin
							if (full) begin
								out_d.status = rsc_pkg::ST_OVERFLOW;
							end else begin
								ctl.head = rsc_pkg::CELL_FROM_ABOVE;
								ctl.body = rsc_pkg::CELL_FROM_ABOVE;
								count_d  = count_q + 1'b1;
							end
						end
						rsc_pkg::OP_ADD, rsc_pkg::OP_SUB: begin
							if (few) begin
								out_d.status = rsc_pkg::ST_UNDERFLOW;
							end else begin
								ctl.head    = rsc_pkg::CELL_FROM_ABOVE;
								ctl.body    = rsc_pkg::CELL_FROM_BELOW;
								ctl.head_in = (cmd.opcode == rsc_pkg::OP_ADD) ? sum_sat : dif_sat;
								count_d     = count_q - 1'b1;
								out_d.kind  = rsc_pkg::KIND_RESULT;
								out_d.value = ctl.head_in;
							end
						end
						rsc_pkg::OP_MUL: begin
							if (few) out_d.status = rsc_pkg::ST_UNDERFLOW;
							else strobe_d = 1'b0;
						end
						rsc_pkg::OP_DIV: begin
							if (few) begin
								out_d.status = rsc_pkg::ST_UNDERFLOW;
							end else if (b_zero) begin
								out_d.status = rsc_pkg::ST_DIV_ZERO;
							end else begin
								strobe_d   = 1'b0;
								dreq.start = 1'b1;
							end
						end
						rsc_pkg::OP_CLEAR: count_d = '0;
						rsc_pkg::OP_SHOW: begin
							if (empty) out_d.kind = rsc_pkg::KIND_EMPTY;
							else strobe_d = 1'b0;
						end
						default: out_d.status = rsc_pkg::ST_BAD_OP;
					endcase
				end
			end
			rsc_pkg::S_MUL, rsc_pkg::S_DIV: begin
				if (state_q == rsc_pkg::S_MUL || drsp.done) begin
					ctl.head    = rsc_pkg::CELL_FROM_ABOVE;
					ctl.body    = rsc_pkg::CELL_FROM_BELOW;
					ctl.head_in = (state_q == rsc_pkg::S_MUL) ? mul_res : div_res;
					count_d     = count_q - 1'b1;
					strobe_d    = 1'b1;
					out_d.kind  = rsc_pkg::KIND_RESULT;
					out_d.value = ctl.head_in;
				end
			end
			rsc_pkg::S_SHOW: begin
				// rotate: the tail cell wraps around into the head
				ctl.head      = rsc_pkg::CELL_FROM_ABOVE;
				ctl.body      = rsc_pkg::CELL_FROM_ABOVE;
				ctl.head_in   = cell_val[D-1];
				strobe_d      = show_emit;
				out_d.kind    = rsc_pkg::KIND_ENTRY;
				out_d.value   = cell_val[D-1];
				out_d.is_last = show_last;
			end
			default: ;
		endcase
		out_d.entries_held = 7'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rsc_pkg::S_IDLE;
			count_q  <= '0;
			step_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			strobe_q <= strobe_d;
			if (state_q == rsc_pkg::S_SHOW) step_q <= step_q + 1'b1;
			else step_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (strobe_d) out_q <= out_d;
		if (accept) begin
			prod_q <= 64'(a_mag) * 64'(b_mag);
			neg_q  <= neg;
		end
	end

	assign strobe = strobe_q;
	assign result = out_q;

endmodule

`default_nettype wire

[hdl/rsc_checker.sv]
// rsc_checker: port-level assertions for rpn_stack_calculator_top, bound to it
// depends on rsc_pkg and on the top level's port list
`timescale 1ns / 1ps
`default_nettype none

module rsc_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input rsc_pkg::cmd_t         cmd,
	input wire logic             strobe,
	input rsc_pkg::result_t      result
);

	logic taken;
	assign taken = start && !busy;

	// a listing never breaks off before its last beat
	a_listing_runs: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.is_last |=> strobe)
		else $error("listing beat not followed by the next entry");

	// push, clear and a bad opcode answer with one acknowledge in the next cycle
	a_quick_ack: assert property (@(posedge clk) disable iff (!arst_n)
		taken && (cmd.opcode == rsc_pkg::OP_PUSH || cmd.opcode == rsc_pkg::OP_CLEAR ||
			cmd.opcode == rsc_pkg::OP_INVALID)
		|=> strobe && result.is_last && result.kind == rsc_pkg::KIND_ACK)
		else $error("missing acknowledge");

	// clear always leaves an empty stack
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		taken && cmd.opcode == rsc_pkg::OP_CLEAR |=> result.entries_held == 7'd0)
		else $error("clear left entries behind");

	// only listing beats may be followed by more beats of the same command
	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.kind != rsc_pkg::KIND_ENTRY |-> result.is_last)
		else $error("non-listing result without last mark");

	// error answers carry a zero value
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status != rsc_pkg::ST_OK |-> result.value == '0)
		else $error("error answer with nonzero value");

endmodule

bind rpn_stack_calculator_top rsc_checker u_rsc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.strobe (strobe),
	.result (result)
);

`default_nettype wire

[verif/rpn_stack_calculator_top_tb.sv]
// rpn_stack_calculator_top_tb: self-checking bench for the rpn calculator with a mirrored stack
// depends on rsc_pkg and rpn_stack_calculator_top; random gaps on the command side
`timescale 1ns / 1ps

module rpn_stack_calculator_top_tb;
	import rsc_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = STACK_DEPTH + 16;
	localparam int TARGET_CMDS = 470;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	cmd_t    cmd = '0;
	logic    busy;
	logic    strobe;
	result_t result;

	cmd_t    pending_cmds[$];
	result_t expected_results[$];

	logic [DATA_W-1:0] stack_mirror[STACK_DEPTH];
	int      depth_mirror = 0;
	int      gap_left = 0;
	bit      idle_on = 1'b1;
	int      mismatches = 0;
	int      quiet_cycles = 0;
	int      fills_done = 0;

	rpn_stack_calculator_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.strobe (strobe),
		.result (result)
	);

	always #6 clk = ~clk;

	function automatic void queue_cmd(opcode_t op, logic [DATA_W-1:0] v);
		cmd_t c;
		c.opcode = op;
		c.operand_value = v;
		pending_cmds.push_back(c);
	endfunction

	// operand mix: mostly small q16.16 numbers, plus extremes, zero and raw words
	function automatic logic [DATA_W-1:0] pick_operand();
		logic [DATA_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = 32'h7FFF_FFFF;
			2: v = 32'h8000_0000;
			3, 9: v = $urandom;
			7: v = $urandom_range(0, 1) ? 32'h0000_0001 : 32'hFFFF_FFFF;
			8: v = ($urandom_range(0, 200) - 100) << FRAC_BITS;
			default: v = $urandom_range(0, 1) ? $urandom_range(0, 8 << FRAC_BITS)
				: -$urandom_range(0, 8 << FRAC_BITS);
		endcase
		return v;
	endfunction

	function automatic void expect_beat(kind_t k, logic [DATA_W-1:0] v, status_t s, bit last);
		result_t r;
		r.kind = k;
		r.value = v;
		r.status = s;
		r.entries_held = 7'(depth_mirror);
		r.is_last = last;
		expected_results.push_back(r);
	endfunction

	function automatic logic [DATA_W-1:0] clip_signed(bit [63:0] mag, bit neg);
		bit [63:0] twos;
		if (neg) begin
			twos = -mag;
			return (mag > 64'h8000_0000) ? 32'h8000_0000 : twos[DATA_W-1:0];
		end
		return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[DATA_W-1:0];
	endfunction

	// mirrors the calculator for one accepted command and queues its beats
	function automatic void predict_calc(cmd_t c);
		logic signed [DATA_W-1:0] lhs, rhs;
		logic [DATA_W-1:0] res;
		longint wide;
		bit [63:0] lmag, rmag, acc, rem;
		bit neg;
		case (c.opcode)
			OP_PUSH: begin
				if (depth_mirror >= STACK_DEPTH) begin
					expect_beat(KIND_ACK, '0, ST_OVERFLOW, 1'b1);
				end else begin
					stack_mirror[depth_mirror] = c.operand_value;
					depth_mirror++;
					expect_beat(KIND_ACK, '0, ST_OK, 1'b1);
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
				if (depth_mirror < 2) begin
					expect_beat(KIND_ACK, '0, ST_UNDERFLOW, 1'b1);
					return;
				end
				rhs = stack_mirror[depth_mirror-1];
				lhs = stack_mirror[depth_mirror-2];
				wide = lhs;
				lmag = (wide < 0) ? -wide : wide;
				wide = rhs;
				rmag = (wide < 0) ? -wide : wide;
				neg = lhs[DATA_W-1] ^ rhs[DATA_W-1];
				if (c.opcode == OP_DIV && rmag == 0) begin
					expect_beat(KIND_ACK, '0, ST_DIV_ZERO, 1'b1);
					return;
				end
				case (c.opcode)
					OP_ADD, OP_SUB: begin
						wide = (c.opcode == OP_ADD) ? longint'(lhs) + longint'(rhs)
							: longint'(lhs) - longint'(rhs);
						if (wide > 64'sd2147483647) res = 32'h7FFF_FFFF;
						else if (wide < -64'sd2147483648) res = 32'h8000_0000;
						else res = wide[DATA_W-1:0];
					end
					OP_MUL: begin
						acc = lmag * rmag;
						if (FRAC_BITS > 0) acc += 64'd1 << (FRAC_BITS - 1);
						acc = acc >> FRAC_BITS;
						res = clip_signed(acc, neg);
					end
					default: begin
						acc = (lmag << FRAC_BITS) / rmag;
						rem = (lmag << FRAC_BITS) % rmag;
						// round half away from zero on the magnitude
						if (2 * rem >= rmag) acc++;
						res = clip_signed(acc, neg);
					end
				endcase
				depth_mirror--;
				stack_mirror[depth_mirror-1] = res;
				expect_beat(KIND_RESULT, res, ST_OK, 1'b1);
			end
			OP_CLEAR: begin
				depth_mirror = 0;
				expect_beat(KIND_ACK, '0, ST_OK, 1'b1);
			end
			OP_SHOW: begin
				if (depth_mirror == 0) begin
					expect_beat(KIND_EMPTY, '0, ST_OK, 1'b1);
				end else begin
					for (int i = 0; i < depth_mirror; i++)
						expect_beat(KIND_ENTRY, stack_mirror[i], ST_OK, i == depth_mirror - 1);
				end
			end
			default: expect_beat(KIND_ACK, '0, ST_BAD_OP, 1'b1);
		endcase
	endfunction

	// command driver: one beat per start/busy handshake, random gap before each
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
			gap_left = 0;
		end else begin
			if (start && !busy) begin
				predict_calc(cmd);
				if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
				gap_left = idle_on ? $urandom_range(0, 8) : 0;
			end
			if (start && busy) begin
				// hold the beat until taken
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left--;
			end else if (pending_cmds.size() > 0) begin
				start <= 1'b1;
				cmd <= pending_cmds.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		result_t want;
		if (arst_n && strobe) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: kind=%0d value=%h status=%0d held=%0d last=%0b",
						result.kind, result.value, result.status, result.entries_held,
						result.is_last);
			end else begin
				want = expected_results.pop_front();
				if (result.kind !== want.kind || result.value !== want.value
						|| result.status !== want.status
						|| result.entries_held !== want.entries_held
						|| result.is_last !== want.is_last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("mismatch: want kind=%0d value=%h status=%0d held=%0d last=%0b",
							want.kind, want.value, want.status, want.entries_held,
							want.is_last);
						$display(", got kind=%0d value=%h status=%0d held=%0d last=%0b",
							result.kind, result.value, result.status,
							result.entries_held, result.is_last);
					end
				end
			end
		end
	end

	// watchdog on cycles with neither a command nor a result beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL rpn_stack_calculator_top");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int n;
		// directed: empty stack, underflow, saturation, rounding, divide by zero, bad opcode
		queue_cmd(OP_SHOW, $urandom);
		queue_cmd(OP_ADD, '0);
		queue_cmd(OP_PUSH, 32'h7FFF_FFFF);
		queue_cmd(OP_PUSH, 32'h7FFF_FFFF);
		queue_cmd(OP_ADD, '0);
		queue_cmd(OP_PUSH, 32'h8000_0000);
		queue_cmd(OP_PUSH, 32'h0000_0001);
		queue_cmd(OP_SUB, '0);
		queue_cmd(OP_PUSH, 32'h8000_0000);
		queue_cmd(OP_MUL, '0);
		queue_cmd(OP_PUSH, '0);
		queue_cmd(OP_DIV, '0);
		queue_cmd(OP_INVALID, 32'hFFFF_FFFF);
		queue_cmd(OP_PUSH, 32'h0001_8000);
		queue_cmd(OP_PUSH, 32'hFFFF_0000);
		queue_cmd(OP_DIV, '0);
		queue_cmd(OP_PUSH, 32'h0000_8000);
		queue_cmd(OP_PUSH, 32'h0000_0001);
		queue_cmd(OP_MUL, '0);
		queue_cmd(OP_PUSH, 32'h0000_0003);
		queue_cmd(OP_PUSH, 32'h7FFF_FFFF);
		queue_cmd(OP_DIV, '0);
		queue_cmd(OP_SHOW, '0);
		queue_cmd(OP_CLEAR, '0);
		queue_cmd(OP_SHOW, '0);

		// random part: expressions, noise and a couple of fill-to-overflow runs
		while (pending_cmds.size() < TARGET_CMDS) begin
			if (fills_done == 0 || (fills_done < 2 && $urandom_range(0, 19) == 0)) begin
				fills_done++;
				queue_cmd(OP_CLEAR, pick_operand());
				repeat (STACK_DEPTH + $urandom_range(1, 3)) queue_cmd(OP_PUSH, pick_operand());
				queue_cmd(OP_SHOW, pick_operand());
				repeat ($urandom_range(1, 4))
					queue_cmd(opcode_t'($urandom_range(OP_ADD, OP_DIV)), pick_operand());
			end else if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 4))
					queue_cmd(opcode_t'($urandom_range(0, 7)), $urandom);
			end else begin
				if ($urandom_range(0, 5) == 0) queue_cmd(OP_CLEAR, $urandom);
				n = $urandom_range(2, 5);
				repeat (n) queue_cmd(OP_PUSH, pick_operand());
				repeat (n - 1)
					queue_cmd(opcode_t'($urandom_range(OP_ADD, OP_DIV)), $urandom);
				if ($urandom_range(0, 2) == 0) queue_cmd(OP_SHOW, $urandom);
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk);
		while (pending_cmds.size() != 0 || start || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_results.size() == 0)
			$display("PASS rpn_stack_calculator_top");
		else
			$display("FAIL rpn_stack_calculator_top");
		$finish;
	end

endmodule
